// ----- rtl/core/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion package
// Shared payload types, widths and the per-step square root state.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int EntryW = 16;
  localparam int SumW   = 18;
  localparam int RadW   = 30;
  localparam int RootW  = 15;
  localparam int RemW   = 17;
  localparam int QuatW  = 16;
  localparam int FracShift = 12;

  localparam logic signed [SumW-1:0] OneQ14 = SumW'(16384);

  typedef struct packed {
    logic signed [EntryW-1:0] r00;
    logic signed [EntryW-1:0] r01;
    logic signed [EntryW-1:0] r02;
    logic signed [EntryW-1:0] r10;
    logic signed [EntryW-1:0] r11;
    logic signed [EntryW-1:0] r12;
    logic signed [EntryW-1:0] r20;
    logic signed [EntryW-1:0] r21;
    logic signed [EntryW-1:0] r22;
  } rmq_in_t;

  typedef struct packed {
    logic        [14:0]      quat_w;
    logic signed [QuatW-1:0] quat_x;
    logic signed [QuatW-1:0] quat_y;
    logic signed [QuatW-1:0] quat_z;
  } rmq_out_t;

  typedef struct packed {
    logic            vld;
    logic            neg;
    logic [RemW-1:0] rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0] rad;
  } root_state_t;

endpackage

// ----- rtl/core/rmq_root_step.sv -----
// ----------------------------------------------------------------------------
// Square root step
// One registered digit of a restoring square root: two radicand bits in,
// one root bit out.
// ----------------------------------------------------------------------------
module rmq_root_step (
  input  logic                 clk,
  input  logic                 rst,
  input  rmq_pkg::root_state_t cur,
  output rmq_pkg::root_state_t nxt
);
  import rmq_pkg::*;

  logic [RemW+1:0]  trial;
  logic [RemW+2:0]  diff;
  root_state_t      nxt_next;

  always_comb begin
    trial    = {cur.rem, cur.rad[RadW-1 -: 2]};
    diff     = {1'b0, trial} - (RemW+3)'({cur.root, 2'b01});
    nxt_next = cur;
    nxt_next.rad = {cur.rad[RadW-3:0], 2'b00};
    if (!diff[RemW+2]) begin
      nxt_next.rem  = diff[RemW-1:0];
      nxt_next.root = {cur.root[RootW-2:0], 1'b1};
    end else begin
      nxt_next.rem  = trial[RemW-1:0];
      nxt_next.root = {cur.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nxt.vld <= 1'b0;
    end else begin
      nxt.vld <= cur.vld;
    end
    nxt.neg  <= nxt_next.neg;
    nxt.rem  <= nxt_next.rem;
    nxt.root <= nxt_next.root;
    nxt.rad  <= nxt_next.rad;
  end

endmodule

// ----- rtl/core/rmq_lane.sv -----
// ----------------------------------------------------------------------------
// Quaternion component lane
// Clamp a signed diagonal sum at zero, take the pipelined half root and
// apply the copied sign.
// ----------------------------------------------------------------------------
module rmq_lane (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             vld,
  input  logic signed [rmq_pkg::SumW-1:0]  sum,
  input  logic                             neg,
  output logic                             out_vld,
  output logic signed [rmq_pkg::QuatW-1:0] value
);
  import rmq_pkg::*;

  root_state_t seed;
  root_state_t st [0:RootW];

  always_comb begin
    seed.vld  = vld;
    seed.neg  = neg;
    seed.rem  = '0;
    seed.root = '0;
    // drop negative sums to zero
    if (sum[SumW-1]) begin
      seed.rad = '0;
    end else begin
      seed.rad = {1'b0, sum[SumW-2:0], FracShift'(0)};
    end
  end

  assign st[0] = seed;

  for (genvar i = 0; i < RootW; i++) begin : g_step
    rmq_root_step u_step (
      .clk (clk),
      .rst (rst),
      .cur (st[i]),
      .nxt (st[i+1])
    );
  end

  logic [QuatW-1:0] mag;

  assign mag     = {1'b0, st[RootW].root};
  assign out_vld = st[RootW].vld;
  assign value   = st[RootW].neg ? signed'(-mag) : signed'(mag);

endmodule

// ----- rtl/core/rotation_matrix_to_quaternion_unit.sv -----
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion unit
// Pipeline: an accepted matrix passes 1 sum register, 15 square root
// registers in each of four lanes and 1 merge register before done is
// high with the result.
// Throughput: one matrix per cycle while busy is low; busy is high only while
// rst is high and in the first cycle after it.
// Reset clears the valid pipeline; no transaction is in flight afterwards.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rmq_pkg::rmq_in_t  item,
  output logic              done,
  output rmq_pkg::rmq_out_t result
);
  import rmq_pkg::*;

  logic signed [SumW-1:0] a00, a11, a22;
  logic signed [EntryW:0] dx, dy, dz;
  logic signed [SumW-1:0] sum_w, sum_x, sum_y, sum_z;
  logic                   neg_x, neg_y, neg_z;
  logic                   sum_vld;
  logic                   accept;

  logic [3:0]              lane_vld;
  logic signed [QuatW-1:0] lane_w, lane_x, lane_y, lane_z;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_comb begin
    a00 = SumW'(item.r00);
    a11 = SumW'(item.r11);
    a22 = SumW'(item.r22);
    dx  = (EntryW+1)'(item.r21) - (EntryW+1)'(item.r12);
    dy  = (EntryW+1)'(item.r02) - (EntryW+1)'(item.r20);
    dz  = (EntryW+1)'(item.r10) - (EntryW+1)'(item.r01);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
    end else begin
      sum_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    sum_w <= OneQ14 + a00 + a11 + a22;
    sum_x <= OneQ14 + a00 - a11 - a22;
    sum_y <= OneQ14 - a00 + a11 - a22;
    sum_z <= OneQ14 - a00 - a11 + a22;
    neg_x <= dx[EntryW];
    neg_y <= dy[EntryW];
    neg_z <= dz[EntryW];
  end

  rmq_lane u_lane_w (
    .clk(clk), .rst(rst), .vld(sum_vld), .sum(sum_w), .neg(1'b0),
    .out_vld(lane_vld[0]), .value(lane_w)
  );

  rmq_lane u_lane_x (
    .clk(clk), .rst(rst), .vld(sum_vld), .sum(sum_x), .neg(neg_x),
    .out_vld(lane_vld[1]), .value(lane_x)
  );

  rmq_lane u_lane_y (
    .clk(clk), .rst(rst), .vld(sum_vld), .sum(sum_y), .neg(neg_y),
    .out_vld(lane_vld[2]), .value(lane_y)
  );

  rmq_lane u_lane_z (
    .clk(clk), .rst(rst), .vld(sum_vld), .sum(sum_z), .neg(neg_z),
    .out_vld(lane_vld[3]), .value(lane_z)
  );

  // merge the four lanes into one result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= &lane_vld;
    end
  end

  always_ff @(posedge clk) begin
    result.quat_w <= lane_w[14:0];
    result.quat_x <= lane_x;
    result.quat_y <= lane_y;
    result.quat_z <= lane_z;
  end

endmodule
